// ----- sv/obc_pkg.sv -----
// Shared constants, register indexes and pipeline control type for the overlap check unit
package obc_pkg;

    localparam int HEADING_WIDTH   = 16;
    localparam int ARC_WIDTH       = 14;
    localparam int HALF_SIZE_WIDTH = 16;
    localparam int TRIG_WIDTH      = 15;
    localparam int UNIT_SHIFT      = 15;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OBSTACLE_X_A        = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OBSTACLE_Y_A        = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OBSTACLE_X_B        = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OBSTACLE_Y_B        = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VEHICLE_HALF_LENGTH = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VEHICLE_HALF_WIDTH  = 3'd5;

    localparam logic [HALF_SIZE_WIDTH-1:0] HALF_LENGTH_RESET = 16'd586;
    localparam logic [HALF_SIZE_WIDTH-1:0] HALF_WIDTH_RESET  = 16'd234;

    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
        logic st4;
    } pipe_adv_t;

endpackage

// ----- sv/obc_trig_lookup.sv -----
// Heading to sine and cosine lookup: quadrant fold, then registered quarter-wave ROM read
module obc_trig_lookup #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                               aclk,
    input  obc_pkg::pipe_adv_t                 adv,
    input  logic [obc_pkg::HEADING_WIDTH-1:0]  heading,
    output logic [obc_pkg::TRIG_WIDTH-1:0]     sin_mag,
    output logic [obc_pkg::TRIG_WIDTH-1:0]     cos_mag,
    output logic                               sin_neg,
    output logic                               cos_neg
);
    import obc_pkg::*;

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = ARC_WIDTH + IDX_W;
    localparam longint unsigned DEPTH_U     = 64'(SINE_TABLE_DEPTH);
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned TRIG_MAX    = 64'd32767;
    localparam logic [IDX_W-1:0] DEPTH_IDX  = IDX_W'(SINE_TABLE_DEPTH);

    function automatic logic [TRIG_WIDTH-1:0] tab_entry(input longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned q;
        if (k >= DEPTH_U) begin
            return TRIG_WIDTH'(TRIG_MAX);
        end
        x  = (k * HALF_PI_Q30) / DEPTH_U;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        q  = (s + 64'd16384) >> 15;
        if (q > TRIG_MAX) begin
            q = TRIG_MAX;
        end
        return TRIG_WIDTH'(q);
    endfunction

    logic [TRIG_WIDTH-1:0] sine_rom [0:SINE_TABLE_DEPTH];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
        assign sine_rom[g] = tab_entry(64'(g));
    end

    logic [1:0]            quad;
    logic [1:0]            cquad;
    logic [ARC_WIDTH-1:0]  arc;
    logic [PROD_W-1:0]     arc_prod;
    logic [IDX_W-1:0]      idx_fwd;
    logic [IDX_W-1:0]      idx_rev;
    logic [IDX_W-1:0]      sin_idx_next;
    logic [IDX_W-1:0]      cos_idx_next;
    logic [IDX_W-1:0]      sin_idx_reg;
    logic [IDX_W-1:0]      cos_idx_reg;
    logic                  sin_neg1_reg;
    logic                  cos_neg1_reg;
    logic [TRIG_WIDTH-1:0] sin_mag_reg;
    logic [TRIG_WIDTH-1:0] cos_mag_reg;
    logic                  sin_neg2_reg;
    logic                  cos_neg2_reg;

    assign quad     = heading[HEADING_WIDTH-1 -: 2];
    assign cquad    = quad + 2'd1;
    assign arc      = heading[ARC_WIDTH-1:0];
    assign arc_prod = PROD_W'(arc) * PROD_W'(DEPTH_IDX);
    assign idx_fwd  = arc_prod[PROD_W-1:ARC_WIDTH];
    assign idx_rev  = DEPTH_IDX - idx_fwd;

    assign sin_idx_next = quad[0]  ? idx_rev : idx_fwd;
    assign cos_idx_next = cquad[0] ? idx_rev : idx_fwd;

    always_ff @(posedge aclk) begin
        if (adv.st1) begin
            sin_idx_reg  <= sin_idx_next;
            cos_idx_reg  <= cos_idx_next;
            sin_neg1_reg <= quad[1];
            cos_neg1_reg <= cquad[1];
        end
        if (adv.st2) begin
            sin_mag_reg  <= sine_rom[sin_idx_reg];
            cos_mag_reg  <= sine_rom[cos_idx_reg];
            sin_neg2_reg <= sin_neg1_reg;
            cos_neg2_reg <= cos_neg1_reg;
        end
    end

    assign sin_mag = sin_mag_reg;
    assign cos_mag = cos_mag_reg;
    assign sin_neg = sin_neg2_reg;
    assign cos_neg = cos_neg2_reg;

endmodule

// ----- sv/obc_sep_axis.sv -----
// Separating-axis test: product stage, then sum, magnitude and compare stage
module obc_sep_axis #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                 aclk,
    input  obc_pkg::pipe_adv_t                   adv,
    input  logic                                 near,
    input  logic signed [COORD_WIDTH+2:0]        sx,
    input  logic signed [COORD_WIDTH+2:0]        sy,
    input  logic [obc_pkg::TRIG_WIDTH-1:0]       sin_mag,
    input  logic [obc_pkg::TRIG_WIDTH-1:0]       cos_mag,
    input  logic                                 sin_neg,
    input  logic                                 cos_neg,
    input  logic [COORD_WIDTH+1:0]               ohl,
    input  logic [COORD_WIDTH+1:0]               ohw,
    input  logic [obc_pkg::HALF_SIZE_WIDTH-1:0]  half_length,
    input  logic [obc_pkg::HALF_SIZE_WIDTH-1:0]  half_width,
    output logic                                 overlap
);
    import obc_pkg::*;

    localparam int SXW = COORD_WIDTH + 3;
    localparam int OW  = COORD_WIDTH + 2;
    localparam int PW  = SXW + TRIG_WIDTH + 1;
    localparam int QW  = OW + TRIG_WIDTH;
    localparam int HW  = HALF_SIZE_WIDTH + 2;
    localparam int RW  = HW + TRIG_WIDTH;
    localparam int CW  = COORD_WIDTH + 21;

    logic signed [TRIG_WIDTH:0] cos_sgn;
    logic signed [TRIG_WIDTH:0] sin_sgn;
    logic [HW-1:0]              h4;
    logic [HW-1:0]              w4;

    logic signed [PW-1:0] p_xc_next, p_ys_next, p_xs_next, p_yc_next;
    logic signed [PW-1:0] p_xc_reg,  p_ys_reg,  p_xs_reg,  p_yc_reg;
    logic [QW-1:0]        q_lc_next, q_ws_next, q_ls_next, q_wc_next;
    logic [QW-1:0]        q_lc_reg,  q_ws_reg,  q_ls_reg,  q_wc_reg;
    logic [RW-1:0]        r_hc_next, r_ws_next, r_hs_next, r_wc_next;
    logic [RW-1:0]        r_hc_reg,  r_ws_reg,  r_hs_reg,  r_wc_reg;
    logic [SXW-1:0]       sx_mag_next, sy_mag_next;
    logic [SXW-1:0]       sx_mag_reg,  sy_mag_reg;
    logic                 near_reg;

    logic signed [PW:0] sum_a;
    logic signed [PW:0] sum_b;
    logic [PW:0]        mag_a;
    logic [PW:0]        mag_b;
    logic [CW-1:0]      rhs_a, rhs_b, lhs_c, rhs_c, lhs_d, rhs_d;
    logic               overlap_next;
    logic               overlap_reg;

    assign cos_sgn = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    assign sin_sgn = sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    assign h4      = {half_length, 2'b00};
    assign w4      = {half_width, 2'b00};

    assign p_xc_next = PW'(sx) * PW'(cos_sgn);
    assign p_ys_next = PW'(sy) * PW'(sin_sgn);
    assign p_xs_next = PW'(sx) * PW'(sin_sgn);
    assign p_yc_next = PW'(sy) * PW'(cos_sgn);

    assign q_lc_next = QW'(ohl) * QW'(cos_mag);
    assign q_ws_next = QW'(ohw) * QW'(sin_mag);
    assign q_ls_next = QW'(ohl) * QW'(sin_mag);
    assign q_wc_next = QW'(ohw) * QW'(cos_mag);

    assign r_hc_next = RW'(h4) * RW'(cos_mag);
    assign r_ws_next = RW'(w4) * RW'(sin_mag);
    assign r_hs_next = RW'(h4) * RW'(sin_mag);
    assign r_wc_next = RW'(w4) * RW'(cos_mag);

    assign sx_mag_next = sx[SXW-1] ? SXW'(-sx) : SXW'(sx);
    assign sy_mag_next = sy[SXW-1] ? SXW'(-sy) : SXW'(sy);

    always_ff @(posedge aclk) begin
        if (adv.st3) begin
            p_xc_reg   <= p_xc_next;
            p_ys_reg   <= p_ys_next;
            p_xs_reg   <= p_xs_next;
            p_yc_reg   <= p_yc_next;
            q_lc_reg   <= q_lc_next;
            q_ws_reg   <= q_ws_next;
            q_ls_reg   <= q_ls_next;
            q_wc_reg   <= q_wc_next;
            r_hc_reg   <= r_hc_next;
            r_ws_reg   <= r_ws_next;
            r_hs_reg   <= r_hs_next;
            r_wc_reg   <= r_wc_next;
            sx_mag_reg <= sx_mag_next;
            sy_mag_reg <= sy_mag_next;
            near_reg   <= near;
        end
        if (adv.st4) begin
            overlap_reg <= overlap_next;
        end
    end

    assign sum_a = (PW+1)'(p_xc_reg) + (PW+1)'(p_ys_reg);
    assign sum_b = (PW+1)'(p_xs_reg) - (PW+1)'(p_yc_reg);
    assign mag_a = sum_a[PW] ? (PW+1)'(-sum_a) : (PW+1)'(sum_a);
    assign mag_b = sum_b[PW] ? (PW+1)'(-sum_b) : (PW+1)'(sum_b);

    assign rhs_a = CW'(q_lc_reg) + CW'(q_ws_reg) + (CW'(h4) << UNIT_SHIFT);
    assign rhs_b = CW'(q_ls_reg) + CW'(q_wc_reg) + (CW'(w4) << UNIT_SHIFT);
    assign lhs_c = CW'(sx_mag_reg) << UNIT_SHIFT;
    assign rhs_c = CW'(r_hc_reg) + CW'(r_ws_reg) + (CW'(ohl) << UNIT_SHIFT);
    assign lhs_d = CW'(sy_mag_reg) << UNIT_SHIFT;
    assign rhs_d = CW'(r_hs_reg) + CW'(r_wc_reg) + (CW'(ohw) << UNIT_SHIFT);

    assign overlap_next = near_reg
                       && (CW'(mag_a) <= rhs_a)
                       && (CW'(mag_b) <= rhs_b)
                       && (lhs_c <= rhs_c)
                       && (lhs_d <= rhs_d);

    assign overlap = overlap_reg;

endmodule

// ----- sv/oriented_box_overlap_check_unit.sv -----
// Top level of the oriented vehicle box versus obstacle box overlap check
//
// Channel | Dir | Handshake        | Word
// s_      | in  | s_valid/s_ready  | four corners, heading, pose number
// m_      | out | m_valid/m_ready  | overlap flag, pose number
// cfg_    | in  | cfg_wr_en        | register index, write data
//
// One word per cycle sustained while m_ready stays high; a result leaves once its word has passed every stage below.
// Four register stages: corner box and sums, coarse test with ROM read, products, compare.
// Reset clears the valid bits and loads the configuration defaults.
// A stage holds while the one after it is full and holding; input is taken whenever any stage has room.
module oriented_box_overlap_check_unit #(
    parameter int MAX_POSES        = 1024,
    parameter int COORD_WIDTH      = 24,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [obc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [COORD_WIDTH-1:0]               cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_WIDTH-1:0]        s_corner0_x,
    input  logic signed [COORD_WIDTH-1:0]        s_corner0_y,
    input  logic signed [COORD_WIDTH-1:0]        s_corner1_x,
    input  logic signed [COORD_WIDTH-1:0]        s_corner1_y,
    input  logic signed [COORD_WIDTH-1:0]        s_corner2_x,
    input  logic signed [COORD_WIDTH-1:0]        s_corner2_y,
    input  logic signed [COORD_WIDTH-1:0]        s_corner3_x,
    input  logic signed [COORD_WIDTH-1:0]        s_corner3_y,
    input  logic [obc_pkg::HEADING_WIDTH-1:0]    s_heading_angle,
    input  logic [$clog2(MAX_POSES)-1:0]         s_pose_number,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_overlap,
    output logic [$clog2(MAX_POSES)-1:0]         m_pose_number_out
);
    import obc_pkg::*;

    localparam int POSE_WIDTH = $clog2(MAX_POSES);
    localparam int SUMW       = COORD_WIDTH + 2;
    localparam int SXW        = COORD_WIDTH + 3;
    localparam int DW         = COORD_WIDTH + 1;

    function automatic logic signed [COORD_WIDTH-1:0] min2(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] max2(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    logic signed [COORD_WIDTH-1:0]     obs_x_a_reg, obs_y_a_reg, obs_x_b_reg, obs_y_b_reg;
    logic [HALF_SIZE_WIDTH-1:0]        half_length_reg, half_width_reg;

    logic       v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic       rdy1, rdy2, rdy3, rdy4;
    pipe_adv_t  adv;

    logic signed [COORD_WIDTH-1:0] cx_min_next, cx_max_next, cy_min_next, cy_max_next;
    logic signed [COORD_WIDTH-1:0] cx_min_reg,  cx_max_reg,  cy_min_reg,  cy_max_reg;
    logic signed [SUMW-1:0]        csum_x_next, csum_y_next;
    logic signed [SUMW-1:0]        csum_x_reg,  csum_y_reg;
    logic [POSE_WIDTH-1:0]         pose1_reg, pose2_reg, pose3_reg, pose4_reg;

    logic signed [COORD_WIDTH-1:0] ox_min, ox_max, oy_min, oy_max;
    logic signed [DW-1:0]          obs_x_sum, obs_y_sum, obs_x_diff, obs_y_diff;
    logic [DW-1:0]                 obs_x_ext, obs_y_ext;
    logic [COORD_WIDTH+1:0]        ohl, ohw;
    logic                          near_next, near_reg;
    logic signed [SXW-1:0]         sx_next, sy_next, sx_reg, sy_reg;

    logic [TRIG_WIDTH-1:0]         sin_mag, cos_mag;
    logic                          sin_neg, cos_neg;
    logic                          overlap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obs_x_a_reg     <= '0;
            obs_y_a_reg     <= '0;
            obs_x_b_reg     <= '0;
            obs_y_b_reg     <= '0;
            half_length_reg <= HALF_LENGTH_RESET;
            half_width_reg  <= HALF_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OBSTACLE_X_A:        obs_x_a_reg     <= cfg_wr_data;
                REG_OBSTACLE_Y_A:        obs_y_a_reg     <= cfg_wr_data;
                REG_OBSTACLE_X_B:        obs_x_b_reg     <= cfg_wr_data;
                REG_OBSTACLE_Y_B:        obs_y_b_reg     <= cfg_wr_data;
                REG_VEHICLE_HALF_LENGTH: half_length_reg <= cfg_wr_data[HALF_SIZE_WIDTH-1:0];
                REG_VEHICLE_HALF_WIDTH:  half_width_reg  <= cfg_wr_data[HALF_SIZE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign rdy4    = !m_valid_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign adv.st1 = rdy1;
    assign adv.st2 = rdy2;
    assign adv.st3 = rdy3;
    assign adv.st4 = rdy4;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg      <= s_valid;
            if (rdy2) v2_reg      <= v1_reg;
            if (rdy3) v3_reg      <= v2_reg;
            if (rdy4) m_valid_reg <= v3_reg;
        end
    end

    assign cx_min_next = min2(min2(s_corner0_x, s_corner1_x), min2(s_corner2_x, s_corner3_x));
    assign cx_max_next = max2(max2(s_corner0_x, s_corner1_x), max2(s_corner2_x, s_corner3_x));
    assign cy_min_next = min2(min2(s_corner0_y, s_corner1_y), min2(s_corner2_y, s_corner3_y));
    assign cy_max_next = max2(max2(s_corner0_y, s_corner1_y), max2(s_corner2_y, s_corner3_y));
    assign csum_x_next = SUMW'(s_corner0_x) + SUMW'(s_corner1_x)
                       + SUMW'(s_corner2_x) + SUMW'(s_corner3_x);
    assign csum_y_next = SUMW'(s_corner0_y) + SUMW'(s_corner1_y)
                       + SUMW'(s_corner2_y) + SUMW'(s_corner3_y);

    assign ox_min = min2(obs_x_a_reg, obs_x_b_reg);
    assign ox_max = max2(obs_x_a_reg, obs_x_b_reg);
    assign oy_min = min2(obs_y_a_reg, obs_y_b_reg);
    assign oy_max = max2(obs_y_a_reg, obs_y_b_reg);

    assign obs_x_sum  = DW'(obs_x_a_reg) + DW'(obs_x_b_reg);
    assign obs_y_sum  = DW'(obs_y_a_reg) + DW'(obs_y_b_reg);
    assign obs_x_diff = DW'(obs_x_b_reg) - DW'(obs_x_a_reg);
    assign obs_y_diff = DW'(obs_y_b_reg) - DW'(obs_y_a_reg);
    assign obs_x_ext  = obs_x_diff[DW-1] ? DW'(-obs_x_diff) : DW'(obs_x_diff);
    assign obs_y_ext  = obs_y_diff[DW-1] ? DW'(-obs_y_diff) : DW'(obs_y_diff);
    assign ohl        = {obs_x_ext, 1'b0};
    assign ohw        = {obs_y_ext, 1'b0};

    assign near_next = !(cx_max_reg < ox_min || cx_min_reg > ox_max
                      || cy_max_reg < oy_min || cy_min_reg > oy_max);
    assign sx_next   = SXW'($signed({obs_x_sum, 1'b0})) - SXW'(csum_x_reg);
    assign sy_next   = SXW'($signed({obs_y_sum, 1'b0})) - SXW'(csum_y_reg);

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            cx_min_reg <= cx_min_next;
            cx_max_reg <= cx_max_next;
            cy_min_reg <= cy_min_next;
            cy_max_reg <= cy_max_next;
            csum_x_reg <= csum_x_next;
            csum_y_reg <= csum_y_next;
            pose1_reg  <= s_pose_number;
        end
        if (rdy2) begin
            near_reg   <= near_next;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
            pose2_reg  <= pose1_reg;
        end
        if (rdy3) begin
            pose3_reg  <= pose2_reg;
        end
        if (rdy4) begin
            pose4_reg  <= pose3_reg;
        end
    end

    obc_trig_lookup #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_trig (
        .aclk    (aclk),
        .adv     (adv),
        .heading (s_heading_angle),
        .sin_mag (sin_mag),
        .cos_mag (cos_mag),
        .sin_neg (sin_neg),
        .cos_neg (cos_neg)
    );

    obc_sep_axis #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sep_axis (
        .aclk        (aclk),
        .adv         (adv),
        .near        (near_reg),
        .sx          (sx_reg),
        .sy          (sy_reg),
        .sin_mag     (sin_mag),
        .cos_mag     (cos_mag),
        .sin_neg     (sin_neg),
        .cos_neg     (cos_neg),
        .ohl         (ohl),
        .ohw         (ohw),
        .half_length (half_length_reg),
        .half_width  (half_width_reg),
        .overlap     (overlap)
    );

    assign m_valid           = m_valid_reg;
    assign m_overlap         = overlap;
    assign m_pose_number_out = pose4_reg;

endmodule

// ----- sv/obc_checker.sv -----
// Port-level checks on the overlap check unit, bound to its top level
module obc_checker #(
    parameter int MAX_POSES = 1024
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [$clog2(MAX_POSES)-1:0]  s_pose_number,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_overlap,
    input logic [$clog2(MAX_POSES)-1:0]  m_pose_number_out
);

    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result shown straight after reset");

    a_room_ahead: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input refused while the pipeline can move");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready
        |=> m_valid && (m_pose_number_out == $past(s_pose_number, 4)))
        else $error("word lost or reordered through a free-running pipeline");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready)
        |=> m_valid && $stable(m_overlap) && $stable(m_pose_number_out))
        else $error("stalled result changed");

endmodule

bind oriented_box_overlap_check_unit obc_checker #(
    .MAX_POSES (MAX_POSES)
) u_obc_checker (.*);
